[design/dirty_page_range_coalescer_assert.svh]
// assertion macros for the port-level checker
// expects clk and arst_n in the scope of each use
`ifndef DIRTY_PAGE_RANGE_COALESCER_ASSERT_SVH
`define DIRTY_PAGE_RANGE_COALESCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dpc assertion failed");

// next-cycle implication, disabled during reset
`define DPC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dpc assertion failed");

`endif

[design/dpc_pkg.sv]
// shared types and constants of the dirty page range coalescer
// no dependencies
package dpc_pkg;

	localparam int MAX_PAGES = 128;
	localparam int IDX_W     = $clog2(MAX_PAGES);
	localparam int CNT_W     = $clog2(MAX_PAGES + 1);

	localparam int SHIFT_W   = 5;
	localparam int REGION_W  = 24;
	localparam int OFFSET_W  = 23;
	localparam int BYTES_W   = 24;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 24;
	localparam int PSIZE_W   = 17;
	localparam int FULL_W    = 17;

	localparam logic [SHIFT_W-1:0]  SHIFT_MIN    = 5'd8;
	localparam logic [SHIFT_W-1:0]  SHIFT_MAX    = 5'd16;
	localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 5'd12;
	localparam logic [REGION_W-1:0] REGION_RESET = 24'd524288;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 1'b1;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} dpc_state_t;

	typedef struct packed {
		logic mark;
		logic start;
		logic step;
		logic emit_last;
		logic clear;
	} dpc_cmd_t;

	typedef struct packed {
		logic any_dirty;
		logic at_end;
		logic run_end;
		logic pend_v;
		logic out_free;
	} dpc_status_t;

endpackage

[design/dpc_req_if.sv]
// input channel: write notices and flush requests
// depends on dpc_pkg
interface dpc_req_if import dpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                action;
	logic [OFFSET_W-1:0] write_offset;

	modport source(output valid, action, write_offset, input ready);
	modport sink(input valid, action, write_offset, output ready);
endinterface

[design/dpc_rsp_if.sv]
// output channel: coalesced dirty ranges
// depends on dpc_pkg
interface dpc_rsp_if import dpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OFFSET_W-1:0] range_offset;
	logic [BYTES_W-1:0]  range_bytes;
	logic                last_range;

	modport source(output valid, range_offset, range_bytes, last_range, input ready);
	modport sink(input valid, range_offset, range_bytes, last_range, output ready);
endinterface

[design/dpc_cfg_if.sv]
// configuration write channel
// depends on dpc_pkg
interface dpc_cfg_if import dpc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[design/dpc_datapath.sv]
// datapath: config registers, dirty bitmap, scan counter, run tracking, output register
// depends on dpc_pkg
module dpc_datapath import dpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dpc_cmd_t             cmd,
	output dpc_status_t          st,
	input  logic [OFFSET_W-1:0]  write_offset,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OFFSET_W-1:0]  range_offset,
	output logic [BYTES_W-1:0]   range_bytes,
	output logic                 last_range
);

	logic [SHIFT_W-1:0]   page_shift_q;
	logic [REGION_W-1:0]  region_bytes_q;
	logic [MAX_PAGES-1:0] map_q;
	logic                 any_dirty_q;
	logic [CNT_W-1:0]     idx_q;
	logic [IDX_W-1:0]     start_q;
	logic                 run_q;
	logic                 pend_v_q;
	logic [OFFSET_W-1:0]  pend_off_q;
	logic [BYTES_W-1:0]   pend_bytes_q;
	logic                 out_v_q;
	logic [OFFSET_W-1:0]  out_off_q;
	logic [BYTES_W-1:0]   out_bytes_q;
	logic                 out_last_q;

	logic [SHIFT_W-1:0]  sh;
	logic [REGION_W-1:0] rmask;
	logic [REGION_W-1:0] quot;
	logic [FULL_W-1:0]   full_pages;
	logic                truly_last;
	logic [CNT_W-1:0]    pages;
	logic [PSIZE_W-1:0]  psize;
	logic [PSIZE_W-1:0]  tail;
	logic [PSIZE_W-1:0]  adj;
	logic [OFFSET_W-1:0] pg;
	logic                hit;
	logic                d;
	logic                at_end;
	logic                run_end;
	logic [CNT_W-1:0]    diff;
	logic [BYTES_W-1:0]  len;
	logic [OFFSET_W-1:0] off_new;
	logic                load;

	// page geometry from the config registers
	always_comb begin
		if (page_shift_q < SHIFT_MIN) begin
			sh = SHIFT_MIN;
		end else if (page_shift_q > SHIFT_MAX) begin
			sh = SHIFT_MAX;
		end else begin
			sh = page_shift_q;
		end
		rmask      = (REGION_W'(1) << sh) - REGION_W'(1);
		quot       = region_bytes_q >> sh;
		full_pages = quot[FULL_W-1:0] + FULL_W'(|(region_bytes_q & rmask));
		truly_last = full_pages <= FULL_W'(MAX_PAGES);
		pages      = truly_last ? full_pages[CNT_W-1:0] : CNT_W'(MAX_PAGES);
		psize      = PSIZE_W'(1) << sh;
		tail       = region_bytes_q[PSIZE_W-1:0] & rmask[PSIZE_W-1:0];
		adj        = (tail == '0) ? '0 : (psize - tail);
	end

	// write notice lookup
	always_comb begin
		pg  = write_offset >> sh;
		hit = ({1'b0, write_offset} < region_bytes_q) && (pg < OFFSET_W'(pages));
	end

	// scan step
	always_comb begin
		d       = (idx_q < pages) && map_q[0];
		at_end  = idx_q == pages;
		run_end = !d && run_q;
		diff    = idx_q - CNT_W'(start_q);
		len     = (BYTES_W'(diff) << sh)
			- ((at_end && truly_last) ? BYTES_W'(adj) : '0);
		off_new = OFFSET_W'(start_q) << sh;
		load    = (cmd.step && run_end && pend_v_q) || cmd.emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q   <= SHIFT_RESET;
			region_bytes_q <= REGION_RESET;
			map_q          <= '0;
			any_dirty_q    <= 1'b0;
			idx_q          <= '0;
			run_q          <= 1'b0;
			pend_v_q       <= 1'b0;
			out_v_q        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_PAGE_SHIFT:   page_shift_q   <= cfg_data[SHIFT_W-1:0];
					CFG_REGION_BYTES: region_bytes_q <= cfg_data[REGION_W-1:0];
				endcase
			end
			if (cmd.clear) begin
				map_q       <= '0;
				any_dirty_q <= 1'b0;
			end else if (cmd.mark && hit) begin
				map_q[pg[IDX_W-1:0]] <= 1'b1;
				any_dirty_q          <= 1'b1;
			end else if (cmd.step) begin
				map_q <= map_q >> 1;
			end
			if (cmd.start) begin
				idx_q    <= '0;
				run_q    <= 1'b0;
				pend_v_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + CNT_W'(1);
				if (d && !run_q) begin
					run_q <= 1'b1;
				end
				if (run_end) begin
					run_q    <= 1'b0;
					pend_v_q <= 1'b1;
				end
			end else if (cmd.emit_last) begin
				pend_v_q <= 1'b0;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && d && !run_q) begin
			start_q <= idx_q[IDX_W-1:0];
		end
		if (cmd.step && run_end) begin
			pend_off_q   <= off_new;
			pend_bytes_q <= len;
		end
		if (load) begin
			out_off_q   <= pend_off_q;
			out_bytes_q <= pend_bytes_q;
			out_last_q  <= cmd.emit_last;
		end
	end

	assign st.any_dirty = any_dirty_q;
	assign st.at_end    = at_end;
	assign st.run_end   = run_end;
	assign st.pend_v    = pend_v_q;
	assign st.out_free  = !out_v_q || out_ready;

	assign out_valid    = out_v_q;
	assign range_offset = out_off_q;
	assign range_bytes  = out_bytes_q;
	assign last_range   = out_last_q;

endmodule

[design/dpc_ctrl.sv]
// controller state machine: accepts items, sequences the bitmap scan
// depends on dpc_pkg
module dpc_ctrl import dpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_action,
	output logic        req_ready,
	input  dpc_status_t st,
	output dpc_cmd_t    cmd
);

	dpc_state_t state_q;
	dpc_state_t state_d;
	logic       stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		stall     = st.run_end && st.pend_v && !st.out_free;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_action == ACT_WRITE) begin
						cmd.mark = 1'b1;
					end else if (st.any_dirty) begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						cmd.clear = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					cmd.step = 1'b1;
					if (st.at_end) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (!st.pend_v || st.out_free) begin
					cmd.emit_last = st.pend_v;
					cmd.clear     = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[design/dirty_page_range_coalescer.sv]
// write notice: accepted in the idle state, input stays ready
// flush with a dirty page: input held off while the scan steps over each tracked page,
// the end of scan and the wrap-up, longer while the output register is held by the sink
// a range waits in a pending register until the next run closes or the scan wraps up,
// then leaves through a one-entry output register; bitmap is a shift register
// reset: async active low, page_shift = 12, region_bytes = 524288, bitmap clear
module dirty_page_range_coalescer import dpc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	dpc_req_if.sink  req,
	dpc_rsp_if.source rsp,
	dpc_cfg_if.sink  cfg
);

	dpc_cmd_t    cmd;
	dpc_status_t st;

	assign cfg.ready = 1'b1;

	dpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.st         (st),
		.cmd        (cmd)
	);

	dpc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.write_offset (req.write_offset),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.range_offset (rsp.range_offset),
		.range_bytes  (rsp.range_bytes),
		.last_range   (rsp.last_range)
	);

endmodule

[design/dpc_checker.sv]
// port-level checks of the dirty page range coalescer, bound to the top level
// depends on dpc_pkg and dirty_page_range_coalescer_assert.svh
`include "dirty_page_range_coalescer_assert.svh"

module dpc_checker import dpc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                req_action,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [OFFSET_W-1:0] rsp_range_offset,
	input logic [BYTES_W-1:0]  rsp_range_bytes,
	input logic                rsp_last_range
);

	// stalled result holds
	`DPC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_range_offset) && $stable(rsp_range_bytes) && $stable(rsp_last_range))
	// a write notice never produces a range
	`DPC_ASSERT_NXT(a_write_no_rsp, req_valid && req_ready && (req_action == ACT_WRITE), !$rose(rsp_valid))
	// ranges are never empty
	`DPC_ASSERT_IMP(a_bytes_nonzero, rsp_valid, rsp_range_bytes != '0)
	// new ranges only come out of a flush in progress
	`DPC_ASSERT_IMP(a_rsp_in_flush, $rose(rsp_valid), !$past(req_ready))

endmodule

bind dirty_page_range_coalescer dpc_checker u_dpc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_action       (req.action),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_range_offset (rsp.range_offset),
	.rsp_range_bytes  (rsp.range_bytes),
	.rsp_last_range   (rsp.last_range)
);

[verif/dirty_page_range_coalescer_tb.sv]
// self-checking testbench for dirty_page_range_coalescer
// drives write notices and flushes, predicts the coalesced dirty ranges, checks each result
// depends on dpc_pkg, dpc_req_if, dpc_rsp_if, dpc_cfg_if and the block itself
module dirty_page_range_coalescer_tb;
	import dpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE = 2 * MAX_PAGES + 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 40;

	typedef struct packed {
		logic                action;
		logic [OFFSET_W-1:0] offset;
	} page_item_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [BYTES_W-1:0]  len;
		logic                last;
	} dirty_range_t;

	logic clk;
	logic arst_n;

	dpc_req_if req_ch();
	dpc_rsp_if rsp_ch();
	dpc_cfg_if cfg_ch();

	dirty_page_range_coalescer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	page_item_t          notice_queue[$];
	dirty_range_t        dirty_ranges[$];
	page_item_t          cur_item;
	dirty_range_t        got_range;
	dirty_range_t        want_range;
	logic [SHIFT_W-1:0]  shadow_shift;
	logic [REGION_W-1:0] shadow_region;
	logic [MAX_PAGES-1:0] page_dirty;
	logic                any_marked;
	bit                  calm;
	int unsigned         items_queued;
	int unsigned         items_accepted;
	int unsigned         mismatch_count;
	int unsigned         cycle_count;

	function automatic void coalesce_item(input page_item_t it);
		int unsigned sh, psize, full, pages, tail, start, len, i, pg;
		logic run, truly_last;
		dirty_range_t found[$];
		dirty_range_t rng;
		sh = (shadow_shift < SHIFT_MIN) ? SHIFT_MIN :
			(shadow_shift > SHIFT_MAX) ? SHIFT_MAX : shadow_shift;
		psize = 1 << sh;
		full = (shadow_region >> sh) + ((shadow_region & (psize - 1)) != 0);
		pages = (full > MAX_PAGES) ? MAX_PAGES : full;
		truly_last = (full == pages);
		tail = shadow_region & (psize - 1);
		if (tail == 0)
			tail = psize;
		if (it.action == ACT_WRITE) begin
			pg = it.offset >> sh;
			if (it.offset < shadow_region && pg < pages) begin
				page_dirty[pg] = 1'b1;
				any_marked = 1'b1;
			end
			return;
		end
		if (any_marked) begin
			run = 1'b0;
			start = 0;
			for (i = 0; i <= pages; i++) begin
				if (i < pages && page_dirty[i]) begin
					if (!run) begin
						run = 1'b1;
						start = i;
					end
				end else if (run) begin
					len = (i - start) << sh;
					run = 1'b0;
					if (i == pages && truly_last)
						len -= psize - tail;
					rng.offset = OFFSET_W'(start << sh);
					rng.len = BYTES_W'(len);
					rng.last = 1'b0;
					found.push_back(rng);
				end
			end
			if (found.size() > 0)
				found[found.size() - 1].last = 1'b1;
			foreach (found[j])
				dirty_ranges.push_back(found[j]);
		end
		page_dirty = '0;
		any_marked = 1'b0;
	endfunction

	task automatic queue_notice(input logic [OFFSET_W-1:0] off);
		page_item_t it;
		it.action = ACT_WRITE;
		it.offset = off;
		notice_queue.push_back(it);
		items_queued++;
	endtask

	task automatic queue_flush();
		page_item_t it;
		it.action = ACT_FLUSH;
		it.offset = OFFSET_W'($urandom);
		notice_queue.push_back(it);
		items_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_PAGE_SHIFT)
			shadow_shift = val[SHIFT_W-1:0];
		else
			shadow_region = val[REGION_W-1:0];
		@(negedge clk);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (items_accepted != items_queued || dirty_ranges.size() != 0);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_phase(input int unsigned n_items);
		int unsigned shift_val, eff, psize, region_val, pages, lim;
		int unsigned made, r, first_pg, run_len;
		shift_val = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(16, 8);
		eff = (shift_val < 8) ? 8 : (shift_val > 16) ? 16 : shift_val;
		psize = 1 << eff;
		case ($urandom_range(5))
			0: region_val = $urandom_range(2000, 1);
			1: region_val = $urandom_range(24'hFFFFFF);
			2: region_val = $urandom_range(128, 1) << eff;
			3: region_val = ($urandom_range(3) == 0) ? 0 : 24'h800000;
			default: region_val = $urandom_range(130 << eff, 1);
		endcase
		pages = (region_val + psize - 1) >> eff;
		if (pages > MAX_PAGES)
			pages = MAX_PAGES;
		lim = (region_val > (1 << OFFSET_W)) ? (1 << OFFSET_W) : region_val;
		write_reg(CFG_PAGE_SHIFT, CFG_DAT_W'(shift_val));
		write_reg(CFG_REGION_BYTES, CFG_DAT_W'(region_val));
		made = 0;
		while (made < n_items) begin
			r = $urandom_range(99);
			if (r < 8) begin
				queue_flush();
				made++;
			end else if (r < 40 && pages > 0) begin
				first_pg = $urandom_range(pages - 1);
				run_len = $urandom_range(8, 1);
				for (int k = 0; k < run_len; k++)
					queue_notice(OFFSET_W'(((first_pg + k) << eff) + $urandom_range(psize - 1)));
				made += run_len;
			end else if (r < 90 && lim > 0) begin
				queue_notice(OFFSET_W'($urandom_range(lim - 1)));
				made++;
			end else begin
				queue_notice(OFFSET_W'($urandom));
				made++;
			end
		end
		queue_flush();
		wait_idle();
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				coalesce_item(cur_item);
				items_accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (notice_queue.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
					cur_item = notice_queue.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.action <= cur_item.action;
					req_ch.write_offset <= cur_item.offset;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// range monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_range.offset = rsp_ch.range_offset;
				got_range.len = rsp_ch.range_bytes;
				got_range.last = rsp_ch.last_range;
				if (dirty_ranges.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected range: off=%h bytes=%h last=%b",
							got_range.offset, got_range.len, got_range.last);
				end else begin
					want_range = dirty_ranges.pop_front();
					if (got_range.offset !== want_range.offset ||
						got_range.len !== want_range.len ||
						got_range.last !== want_range.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("range mismatch: expected off=%h bytes=%h last=%b, got off=%h bytes=%h last=%b",
								want_range.offset, want_range.len, want_range.last,
								got_range.offset, got_range.len, got_range.last);
					end
				end
			end
			rsp_ch.ready <= calm || ($urandom_range(99) >= 28);
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_WRITE;
		req_ch.write_offset = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_PAGE_SHIFT;
		cfg_ch.data = '0;
		shadow_shift = SHIFT_RESET;
		shadow_region = REGION_RESET;
		page_dirty = '0;
		any_marked = 1'b0;
		calm = 1'b0;
		items_queued = 0;
		items_accepted = 0;
		mismatch_count = 0;
		cycle_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: first and last page, offsets past the region
		queue_notice(23'd0);
		queue_notice(23'd524287);
		queue_notice(23'd524288);
		queue_notice(23'd8388607);
		queue_notice(23'd4096);
		queue_flush();
		wait_idle();

		// page shift below range, partial last page
		write_reg(CFG_PAGE_SHIFT, 24'd3);
		write_reg(CFG_REGION_BYTES, 24'd1000);
		queue_notice(23'd999);
		queue_notice(23'd0);
		queue_flush();
		queue_notice(23'd512);
		queue_notice(23'd768);
		queue_flush();
		wait_idle();

		// page shift above range, region spanning the whole offset space
		write_reg(CFG_PAGE_SHIFT, 24'd31);
		write_reg(CFG_REGION_BYTES, 24'h800000);
		queue_notice(23'd8388607);
		queue_notice(23'd0);
		queue_notice(23'd65536);
		queue_flush();
		wait_idle();

		// region wider than the tracked pages
		write_reg(CFG_PAGE_SHIFT, 24'd8);
		queue_notice(23'd32517);
		queue_notice(23'd32768);
		queue_flush();
		wait_idle();

		// empty region, then a one-byte region
		write_reg(CFG_REGION_BYTES, 24'd0);
		queue_notice(23'd0);
		queue_flush();
		wait_idle();
		write_reg(CFG_PAGE_SHIFT, 24'd16);
		write_reg(CFG_REGION_BYTES, 24'd1);
		queue_notice(23'd0);
		queue_flush();
		wait_idle();

		// region shrinks between the notices and the flush
		write_reg(CFG_PAGE_SHIFT, 24'd8);
		write_reg(CFG_REGION_BYTES, 24'd65536);
		queue_notice(23'd2560);
		queue_notice(23'd30000);
		wait_idle();
		write_reg(CFG_REGION_BYTES, 24'd12800);
		queue_flush();
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			calm = (p == 3);
			random_phase(PHASE_ITEMS);
		end
		calm = 1'b0;

		if (mismatch_count == 0 && dirty_ranges.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
